// File: rtl/b64sc_pkg.sv
// Shared types, constants and alphabet functions for the Base64 stream codec.
// No dependencies; imported by every rtl module of the block.
package b64sc_pkg;

  localparam int FifoDepth = 4;
  localparam int FifoAw    = $clog2(FifoDepth);

  localparam logic [7:0] PadChar = 8'h3D;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpZ   = 8'h5A;
  localparam logic [7:0] ChLoA   = 8'h61;
  localparam logic [7:0] ChLoZ   = 8'h7A;
  localparam logic [7:0] ChDig0  = 8'h30;
  localparam logic [7:0] ChDig9  = 8'h39;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChSlash = 8'h2F;

  localparam logic [5:0] SxLoBase  = 6'd26;
  localparam logic [5:0] SxDigBase = 6'd52;
  localparam logic [5:0] SxPlus    = 6'd62;
  localparam logic [5:0] SxSlash   = 6'd63;

  // one queued work unit: up to four result bytes
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;  // number of results minus one
    logic            bare;      // end marker without a byte
    logic            eom;
  } job_t;

  function automatic logic [7:0] b64_char(input logic [5:0] sx);
    logic [7:0] ch;
    if (sx < SxLoBase) begin
      ch = ChUpA + {2'b00, sx};
    end else if (sx < SxDigBase) begin
      ch = ChLoA + {2'b00, sx - SxLoBase};
    end else if (sx < SxPlus) begin
      ch = ChDig0 + {2'b00, sx - SxDigBase};
    end else if (sx == SxPlus) begin
      ch = ChPlus;
    end else begin
      ch = ChSlash;
    end
    return ch;
  endfunction

  // bit 6 = valid, bits 5..0 = sextet
  function automatic logic [6:0] b64_sextet(input logic [7:0] ch);
    logic [6:0] v;
    if (ch >= ChUpA && ch <= ChUpZ) begin
      v = {1'b1, 6'(ch - ChUpA)};
    end else if (ch >= ChLoA && ch <= ChLoZ) begin
      v = {1'b1, 6'(ch - ChLoA) + SxLoBase};
    end else if (ch >= ChDig0 && ch <= ChDig9) begin
      v = {1'b1, 6'(ch - ChDig0) + SxDigBase};
    end else if (ch == ChPlus) begin
      v = {1'b1, SxPlus};
    end else if (ch == ChSlash) begin
      v = {1'b1, SxSlash};
    end else begin
      v = 7'd0;
    end
    return v;
  endfunction

endpackage

// File: rtl/b64sc_front.sv
// Front end: accepts input transactions and the mode register, keeps the
// group state and turns input bytes into jobs for the queue. Uses b64sc_pkg.
module b64sc_front import b64sc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_tvalid,
  output logic       cfg_tready,
  input  logic [7:0] cfg_tdata,   // [0] decode_mode
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,    // [7:0] data_byte
  input  logic       in_tlast,    // last
  input  logic       q_full,
  output logic       q_push,
  output job_t       q_job
);

  logic        mode_r;
  logic [1:0]  phase_r, phase_nxt;
  logic [20:0] held_r, held_nxt;
  logic        stopped_r, stopped_nxt;

  logic        in_fire;
  logic [6:0]  sx, ha, hb, hc;
  logic [5:0]  cs;
  logic [2:0]  cnt;
  job_t        job;

  assign cfg_tready = 1'b1;
  assign in_tready  = !q_full;
  assign in_fire    = in_tvalid && in_tready;
  assign sx = b64_sextet(in_tdata);
  assign ha = held_r[6:0];
  assign hb = held_r[13:7];
  assign hc = held_r[20:14];
  assign cs = hc[6] ? hc[5:0] : SxSlash;

  always_comb begin
    job         = '0;
    cnt         = 3'd0;
    phase_nxt   = phase_r;
    held_nxt    = held_r;
    stopped_nxt = stopped_r;
    if (!mode_r) begin
      case (phase_r)
        2'd0: begin
          job.bytes[0] = b64_char(in_tdata[7:2]);
          job.bytes[1] = b64_char({in_tdata[1:0], 4'b0000});
          job.bytes[2] = PadChar;
          job.bytes[3] = PadChar;
          cnt          = in_tlast ? 3'd4 : 3'd1;
          held_nxt     = {19'd0, in_tdata[1:0]};
          phase_nxt    = 2'd1;
        end
        2'd1: begin
          job.bytes[0] = b64_char({held_r[1:0], in_tdata[7:4]});
          job.bytes[1] = b64_char({in_tdata[3:0], 2'b00});
          job.bytes[2] = PadChar;
          cnt          = in_tlast ? 3'd3 : 3'd1;
          held_nxt     = {17'd0, in_tdata[3:0]};
          phase_nxt    = 2'd2;
        end
        default: begin
          job.bytes[0] = b64_char({held_r[3:0], in_tdata[7:6]});
          job.bytes[1] = b64_char(in_tdata[5:0]);
          cnt          = 3'd2;
          held_nxt     = '0;
          phase_nxt    = 2'd0;
        end
      endcase
    end else if (!stopped_r) begin
      if (phase_r != 2'd3) begin
        case (phase_r)
          2'd0:    held_nxt = {held_r[20:7], sx};
          2'd1:    held_nxt = {held_r[20:14], sx, held_r[6:0]};
          default: held_nxt = {sx, held_r[13:0]};
        endcase
        phase_nxt = phase_r + 2'd1;
      end else begin
        held_nxt  = '0;
        phase_nxt = 2'd0;
        if (!(ha[6] && hb[6])) begin
          stopped_nxt = 1'b1;
        end else begin
          job.bytes[0] = {ha[5:0], hb[5:4]};
          job.bytes[1] = hc[6] ? {hb[3:0], hc[5:2]} : {cs[1:0], sx[5:0]};
          job.bytes[2] = {cs[1:0], sx[5:0]};
          cnt          = 3'd1 + {2'b00, hc[6]} + {2'b00, sx[6]};
        end
      end
    end
    if (in_tlast) begin
      phase_nxt   = 2'd0;
      held_nxt    = '0;
      stopped_nxt = 1'b0;
      job.eom     = 1'b1;
      if (cnt == 3'd0) begin
        job.bare = 1'b1;
        cnt      = 3'd1;
      end
    end
    job.last_idx = 2'(cnt - 3'd1);
  end

  assign q_push = in_fire && (cnt != 3'd0);
  assign q_job  = job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= 1'b0;
      phase_r   <= '0;
      held_r    <= '0;
      stopped_r <= 1'b0;
    end else if (cfg_tvalid && cfg_tready) begin
      mode_r    <= cfg_tdata[0];
      phase_r   <= '0;
      held_r    <= '0;
      stopped_r <= 1'b0;
    end else if (in_fire) begin
      phase_r   <= phase_nxt;
      held_r    <= held_nxt;
      stopped_r <= stopped_nxt;
    end
  end

  a_stop_only_decode: assert property (@(posedge clk) disable iff (!rst_n)
    stopped_r |-> mode_r)
    else $error("decode stop flag set in encode mode");

endmodule

// File: rtl/b64sc_fifo.sv
// Short job queue between front end and back end.
// Uses job_t and FifoDepth from b64sc_pkg.
module b64sc_fifo import b64sc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head_job,
  output logic empty,
  output logic full
);

  job_t              entries_r [FifoDepth];
  logic [FifoAw-1:0] wptr_r, rptr_r;
  logic [FifoAw:0]   cnt_r;

  assign empty    = (cnt_r == '0);
  assign full     = (cnt_r == (FifoAw+1)'(FifoDepth));
  assign head_job = entries_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + 1'b1;
      if (pop)  rptr_r <= rptr_r + 1'b1;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("job queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("job queue underflow");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (FifoAw+1)'(FifoDepth))
    else $error("job queue count out of range");

endmodule

// File: rtl/b64sc_back.sv
// Back end: takes queued jobs and issues their bytes one per cycle while
// not stalled, via a registered output stage. Uses job_t from b64sc_pkg.
module b64sc_back import b64sc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  job_t       head_job,
  input  logic       q_empty,
  output logic       q_pop,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,   // [7:0] out_byte
  output logic       out_tuser,   // has_byte
  output logic       out_tlast    // end_of_message
);

  job_t       cur_r;
  logic       cur_valid_r, cur_valid_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       ovalid_r, ovalid_nxt;
  logic [7:0] obyte_r, obyte_nxt;
  logic       ohas_r, ohas_nxt;
  logic       olast_r, olast_nxt;
  logic       adv, final_one;

  assign adv       = cur_valid_r && (!ovalid_r || out_tready);
  assign final_one = (idx_r == cur_r.last_idx);
  assign q_pop     = !q_empty && (!cur_valid_r || (adv && final_one));

  always_comb begin
    cur_valid_nxt = cur_valid_r;
    idx_nxt       = idx_r;
    ovalid_nxt    = ovalid_r;
    obyte_nxt     = obyte_r;
    ohas_nxt      = ohas_r;
    olast_nxt     = olast_r;
    if (adv) begin
      ovalid_nxt = 1'b1;
      obyte_nxt  = cur_r.bytes[idx_r];
      ohas_nxt   = !cur_r.bare;
      olast_nxt  = cur_r.eom && final_one;
    end else if (out_tready) begin
      ovalid_nxt = 1'b0;
    end
    if (q_pop) begin
      cur_valid_nxt = 1'b1;
      idx_nxt       = '0;
    end else if (adv && final_one) begin
      cur_valid_nxt = 1'b0;
    end else if (adv) begin
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= '0;
      ovalid_r    <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      idx_r       <= idx_nxt;
      ovalid_r    <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur_r <= head_job;
    obyte_r <= obyte_nxt;
    ohas_r  <= ohas_nxt;
    olast_r <= olast_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = obyte_r;
  assign out_tuser  = ohas_r;
  assign out_tlast  = olast_r;

  a_bare_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tlast && out_tdata == 8'd0))
    else $error("bare marker without end of message or with data");

  a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> (idx_r <= cur_r.last_idx))
    else $error("result index beyond job length");

endmodule

// File: rtl/base64_stream_codec.sv
// Base64 stream codec, standard alphabet, encode or decode by mode register.
// First result of a transaction passes the job queue, the current-job register
// and the output register. Throughput: one result per cycle unless out_tready
// stalls; a byte is taken every cycle while the four-entry job queue has room.
// Reset (synchronous, rst_n low): encode mode, group state and queue cleared.
// Top level; instantiates b64sc_front, b64sc_fifo and b64sc_back.
module base64_stream_codec import b64sc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_tvalid,
  output logic       cfg_tready,
  input  logic [7:0] cfg_tdata,   // [0] decode_mode
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,    // [7:0] data_byte
  input  logic       in_tlast,    // last
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,   // [7:0] out_byte
  output logic       out_tuser,   // has_byte
  output logic       out_tlast    // end_of_message
);

  logic q_push, q_pop, q_full, q_empty;
  job_t push_job, head_job;

  b64sc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_tvalid (cfg_tvalid),
    .cfg_tready (cfg_tready),
    .cfg_tdata  (cfg_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_job      (push_job)
  );

  b64sc_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head_job (head_job),
    .empty    (q_empty),
    .full     (q_full)
  );

  b64sc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_job   (head_job),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
